// ===== design/fba_pkg.sv =====
// fba_pkg: shared widths, constants, register codes and beat/stage structs
// for the forward/backward asymmetry pipeline. No dependencies.
`default_nettype none

package fba_pkg;

    // Field and arithmetic widths
    localparam int COUNT_W  = 32;
    localparam int ALPHA_W  = 16;
    localparam int FRAC_K   = 12;
    localparam int TIME_W   = 32;
    localparam int ASYM_W   = 16;
    localparam int ERR_W    = 24;
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;

    localparam int FS_W     = COUNT_W + FRAC_K;       // F scaled by 2^K
    localparam int AB_W     = ALPHA_W + COUNT_W;      // alpha * B
    localparam int DEN_W    = AB_W + 1;               // F*2^K + alpha*B
    localparam int QUO_W    = ASYM_W;                 // rounded |A| magnitude
    localparam int AA_W     = 2 * ALPHA_W;            // alpha^2
    localparam int AAB_W    = AA_W + COUNT_W;         // alpha^2 * B
    localparam int Q1_W     = AAB_W + 1;
    localparam int Q2_W     = 2 * QUO_W;
    localparam int SPLIT_W  = 32;                     // multiplier slice width
    localparam int DH_W     = DEN_W - SPLIT_W;
    localparam int Q1H_W    = Q1_W - SPLIT_W;
    localparam int PROD_W   = Q1_W + Q2_W;            // Q1 * Q2
    localparam int NUM_W    = PROD_W + 2;             // Q1 * Q2 * 4
    localparam int D2_W     = 2 * DEN_W;
    localparam int X_W      = 34;                     // error^2 quotient
    localparam int ROOT_W   = X_W / 2;
    localparam int SQ_REM_W = ROOT_W + 1;

    localparam logic [ALPHA_W-1:0]       ALPHA_RESET = ALPHA_W'(4096);
    localparam logic [AA_W-1:0]          AA_RESET    = AA_W'(ALPHA_RESET) * AA_W'(ALPHA_RESET);
    localparam logic [Q2_W-1:0]          Q2_BASE     = Q2_W'(64'd1 << (2 * QUO_W - 2));
    localparam logic [ERR_W-1:0]         ERR_ONE     = ERR_W'(65536);
    localparam logic [ERR_W-1:0]         ERR_BOUND   = ERR_W'(92682);
    localparam logic signed [ASYM_W-1:0] ASYM_MAX    = ASYM_W'(32767);

    typedef enum logic [0:0] {
        REG_BALANCE_ALPHA  = 1'b0,
        REG_HISTOGRAM_MODE = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic [COUNT_W-1:0] forward_count;
        logic [COUNT_W-1:0] backward_count;
        logic [TIME_W-1:0]  bin_start;
        logic [TIME_W-1:0]  bin_end;
    } sample_t;

    typedef struct packed {
        logic signed [ASYM_W-1:0] asymmetry;
        logic [ERR_W-1:0]         asym_error;
        logic [TIME_W-1:0]        bin_time;
        logic                     zero_denominator;
        logic                     saturated;
    } result_t;

    // Side data riding along the asymmetry divider
    typedef struct packed {
        logic [Q1_W-1:0]          q1;
        logic [2*SPLIT_W-1:0]     pll;
        logic [SPLIT_W+DH_W-1:0]  plh;
        logic [2*DH_W-1:0]        phh;
        logic [TIME_W-1:0]        btime;
        logic                     zero;
    } qside_t;

    typedef struct packed {
        logic [DEN_W-1:0] den;
        logic [DEN_W-1:0] rem;
        logic             nbit;
        logic [QUO_W-1:0] quo;
        logic             neg;
        qside_t           side;
    } qdiv_t;

    // Side data riding along the error divider and root
    typedef struct packed {
        logic signed [ASYM_W-1:0] asym;
        logic                     sat;
        logic                     zero;
        logic [TIME_W-1:0]        btime;
    } xside_t;

    typedef struct packed {
        logic [D2_W-1:0] d2;
        logic [D2_W-1:0] rem;
        logic [X_W-1:0]  low;
        logic [X_W-1:0]  quo;
        xside_t          side;
    } xdiv_t;

    typedef struct packed {
        logic [X_W-1:0]      x;
        logic [SQ_REM_W-1:0] rem;
        logic [ROOT_W-1:0]   root;
        xside_t              side;
    } sqrt_t;

endpackage

`default_nettype wire

// ===== design/forward_backward_asymmetry.sv =====
// forward_backward_asymmetry: top level, asymmetry A=(F-aB)/(F+aB), its
// error and the bin time per beat. Depends on fba_pkg, fba_qdiv, fba_xroot.
//
//  channel  | handshake               | payload           | dir
//  ---------+-------------------------+-------------------+-----
//  sample   | sample_valid/ready      | fba_pkg::sample_t | in
//  result   | result_valid/ready      | fba_pkg::result_t | out
//  config   | psel/penable/pwrite/... | pwdata / prdata   | APB
//
// One beat per cycle while the skid register is empty; each beat passes through
// three front stages, 16 asymmetry divide stages, four multiply stages,
// 34 error divide stages, 17 square root stages and the output register.
// The whole pipeline advances together; it holds only while the skid
// register behind the output register is occupied, so sample_ready is a
// flop output. rst_n clears valids and loads the register reset values.
// Registers: 0x0 balance_alpha (Q4.12), 0x4 histogram_mode.
`default_nettype none

module forward_backward_asymmetry (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          sample_valid,
    output logic                               sample_ready,
    input  wire fba_pkg::sample_t              sample,
    output logic                               result_valid,
    input  wire logic                          result_ready,
    output fba_pkg::result_t                   result,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [fba_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [fba_pkg::PDATA_W-1:0]   pwdata,
    output logic [fba_pkg::PDATA_W-1:0]        prdata,
    output logic                               pready
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [fba_pkg::ALPHA_W-1:0] alpha_reg;
    logic                        hist_reg;
    logic [fba_pkg::AA_W-1:0]    aa_reg;      // alpha^2, follows alpha_reg
    fba_pkg::reg_idx_t           preg_idx;
    logic                        wr_en;

    assign pready   = 1'b1;
    assign preg_idx = fba_pkg::reg_idx_t'(paddr[fba_pkg::PADDR_W-1]);
    assign wr_en    = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg <= fba_pkg::ALPHA_RESET;
            hist_reg  <= 1'b1;
            aa_reg    <= fba_pkg::AA_RESET;
        end
        else
        begin
            aa_reg <= fba_pkg::AA_W'(alpha_reg) * fba_pkg::AA_W'(alpha_reg);
            if (wr_en)
            begin
                unique case (preg_idx)
                    fba_pkg::REG_BALANCE_ALPHA:  alpha_reg <= pwdata[fba_pkg::ALPHA_W-1:0];
                    fba_pkg::REG_HISTOGRAM_MODE: hist_reg  <= pwdata[0];
                endcase
            end
        end
    end

    always_comb
    begin
        unique case (preg_idx)
            fba_pkg::REG_BALANCE_ALPHA:  prdata = fba_pkg::PDATA_W'(alpha_reg);
            fba_pkg::REG_HISTOGRAM_MODE: prdata = fba_pkg::PDATA_W'(hist_reg);
        endcase
    end

    // ------------------------------------------------------------------
    // Global advance: the pipe moves unless the skid register is holding
    // ------------------------------------------------------------------
    logic out_valid_reg;
    logic skid_valid_reg;
    logic adv;

    assign adv          = !skid_valid_reg;
    assign sample_ready = adv;

    // ------------------------------------------------------------------
    // Stage A: alpha*B and bin time
    // ------------------------------------------------------------------
    logic                         a_valid_reg;
    logic [fba_pkg::COUNT_W-1:0]  a_f_reg;
    logic [fba_pkg::COUNT_W-1:0]  a_b_reg;
    logic [fba_pkg::AB_W-1:0]     a_ab_reg;
    logic [fba_pkg::TIME_W-1:0]   a_btime_reg;
    logic [fba_pkg::TIME_W:0]     span_sum;

    assign span_sum = {1'b0, sample.bin_start} + {1'b0, sample.bin_end};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_valid_reg <= sample_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_f_reg     <= sample.forward_count;
            a_b_reg     <= sample.backward_count;
            a_ab_reg    <= fba_pkg::AB_W'(alpha_reg) * fba_pkg::AB_W'(sample.backward_count);
            a_btime_reg <= hist_reg ? span_sum[fba_pkg::TIME_W:1] : sample.bin_start;
        end
    end

    // ------------------------------------------------------------------
    // Stage B: denominator, signed numerator magnitude, alpha^2*B
    // ------------------------------------------------------------------
    logic                         b_valid_reg;
    logic [fba_pkg::DEN_W-1:0]    b_den_reg;
    logic [fba_pkg::DEN_W-1:0]    b_mag_reg;
    logic                         b_neg_reg;
    logic [fba_pkg::AAB_W-1:0]    b_aab_reg;
    logic [fba_pkg::COUNT_W-1:0]  b_f_reg;
    logic [fba_pkg::TIME_W-1:0]   b_btime_reg;
    logic                         b_zero_reg;

    logic [fba_pkg::DEN_W-1:0]    fs_ext;
    logic [fba_pkg::DEN_W-1:0]    ab_ext;
    logic [fba_pkg::DEN_W-1:0]    den_next;
    logic                         neg_next;

    assign fs_ext   = fba_pkg::DEN_W'({a_f_reg, {fba_pkg::FRAC_K{1'b0}}});
    assign ab_ext   = fba_pkg::DEN_W'(a_ab_reg);
    assign den_next = fs_ext + ab_ext;
    assign neg_next = ab_ext > fs_ext;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b_den_reg   <= den_next;
            b_mag_reg   <= neg_next ? (ab_ext - fs_ext) : (fs_ext - ab_ext);
            b_neg_reg   <= neg_next;
            b_aab_reg   <= fba_pkg::AAB_W'(aa_reg) * fba_pkg::AAB_W'(a_b_reg);
            b_f_reg     <= a_f_reg;
            b_btime_reg <= a_btime_reg;
            b_zero_reg  <= (den_next == '0);
        end
    end

    // ------------------------------------------------------------------
    // Stage C: Q1, partial products of D^2, divider load
    // ------------------------------------------------------------------
    logic                         c_valid_reg;
    fba_pkg::qdiv_t               c_reg;
    fba_pkg::qdiv_t               c_next;
    logic [fba_pkg::SPLIT_W-1:0]  den_lo;
    logic [fba_pkg::DH_W-1:0]     den_hi;

    assign den_lo = b_den_reg[fba_pkg::SPLIT_W-1:0];
    assign den_hi = b_den_reg[fba_pkg::DEN_W-1:fba_pkg::SPLIT_W];

    always_comb
    begin
        c_next            = '0;
        c_next.den        = b_den_reg;
        c_next.rem        = fba_pkg::DEN_W'(b_mag_reg[fba_pkg::DEN_W-1:1]);
        c_next.nbit       = b_mag_reg[0];
        c_next.neg        = b_neg_reg;
        c_next.side.q1    = fba_pkg::Q1_W'({b_f_reg, {(2 * fba_pkg::FRAC_K){1'b0}}})
                          + fba_pkg::Q1_W'(b_aab_reg);
        c_next.side.pll   = (2 * fba_pkg::SPLIT_W)'(den_lo) * (2 * fba_pkg::SPLIT_W)'(den_lo);
        c_next.side.plh   = (fba_pkg::SPLIT_W + fba_pkg::DH_W)'(den_lo)
                          * (fba_pkg::SPLIT_W + fba_pkg::DH_W)'(den_hi);
        c_next.side.phh   = (2 * fba_pkg::DH_W)'(den_hi) * (2 * fba_pkg::DH_W)'(den_hi);
        c_next.side.btime = b_btime_reg;
        c_next.side.zero  = b_zero_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c_reg <= c_next;
        end
    end

    // ------------------------------------------------------------------
    // 16-stage divider: quotient of |N|*2^15 by D
    // ------------------------------------------------------------------
    logic           qd_valid;
    fba_pkg::qdiv_t qd;

    fba_qdiv u_qdiv (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .src_valid (c_valid_reg),
        .src       (c_reg),
        .dst_valid (qd_valid),
        .dst       (qd)
    );

    // ------------------------------------------------------------------
    // Stage E: round half away, sign and clamp; sum D^2
    // ------------------------------------------------------------------
    logic                              e_valid_reg;
    logic [fba_pkg::QUO_W-1:0]         e_q_reg;
    fba_pkg::xside_t                   e_side_reg;
    logic [fba_pkg::D2_W-1:0]          e_d2_reg;
    logic [fba_pkg::Q1_W-1:0]          e_q1_reg;

    logic                              rnd_up;
    logic [fba_pkg::QUO_W-1:0]         q_rnd;
    logic [fba_pkg::QUO_W-1:0]         q_negated;
    fba_pkg::xside_t                   e_side_next;

    assign rnd_up    = {qd.rem, 1'b0} >= {1'b0, qd.den};
    assign q_rnd     = qd.quo + fba_pkg::QUO_W'(rnd_up);
    assign q_negated = fba_pkg::QUO_W'(0) - q_rnd;

    always_comb
    begin
        e_side_next       = '0;
        e_side_next.zero  = qd.side.zero;
        e_side_next.btime = qd.side.btime;
        priority if (qd.neg)
        begin
            e_side_next.asym = $signed(q_negated);
        end
        else if (q_rnd[fba_pkg::QUO_W-1])
        begin
            // +1.0 does not fit Q1.15
            e_side_next.asym = fba_pkg::ASYM_MAX;
            e_side_next.sat  = 1'b1;
        end
        else
        begin
            e_side_next.asym = $signed(q_rnd);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            e_valid_reg <= qd_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            e_q_reg    <= q_rnd;
            e_side_reg <= e_side_next;
            e_q1_reg   <= qd.side.q1;
            e_d2_reg   <= fba_pkg::D2_W'({qd.side.phh, {(2 * fba_pkg::SPLIT_W){1'b0}}})
                        + fba_pkg::D2_W'({qd.side.plh, {(fba_pkg::SPLIT_W + 1){1'b0}}})
                        + fba_pkg::D2_W'(qd.side.pll);
        end
    end

    // ------------------------------------------------------------------
    // Stage F: q^2
    // ------------------------------------------------------------------
    logic                      f_valid_reg;
    logic [fba_pkg::Q2_W-1:0]  f_qq_reg;
    fba_pkg::xside_t           f_side_reg;
    logic [fba_pkg::D2_W-1:0]  f_d2_reg;
    logic [fba_pkg::Q1_W-1:0]  f_q1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            f_valid_reg <= e_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            f_qq_reg   <= fba_pkg::Q2_W'(e_q_reg) * fba_pkg::Q2_W'(e_q_reg);
            f_side_reg <= e_side_reg;
            f_d2_reg   <= e_d2_reg;
            f_q1_reg   <= e_q1_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage G: Q2 = 2^30 + q^2, Q1*Q2 in two slices
    // ------------------------------------------------------------------
    localparam int PL_W = fba_pkg::SPLIT_W + fba_pkg::Q2_W;
    localparam int PH_W = fba_pkg::Q1H_W + fba_pkg::Q2_W;

    logic                      g_valid_reg;
    logic [PL_W-1:0]           g_pl_reg;
    logic [PH_W-1:0]           g_ph_reg;
    fba_pkg::xside_t           g_side_reg;
    logic [fba_pkg::D2_W-1:0]  g_d2_reg;
    logic [fba_pkg::Q2_W-1:0]  q2;

    assign q2 = fba_pkg::Q2_BASE + f_qq_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            g_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            g_valid_reg <= f_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            g_pl_reg   <= PL_W'(f_q1_reg[fba_pkg::SPLIT_W-1:0]) * PL_W'(q2);
            g_ph_reg   <= PH_W'(f_q1_reg[fba_pkg::Q1_W-1:fba_pkg::SPLIT_W]) * PH_W'(q2);
            g_side_reg <= f_side_reg;
            g_d2_reg   <= f_d2_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage H: numerator 4*Q1*Q2, error divider load
    // ------------------------------------------------------------------
    logic                        h_valid_reg;
    fba_pkg::xdiv_t              h_reg;
    fba_pkg::xdiv_t              h_next;
    logic [fba_pkg::PROD_W-1:0]  prod;
    logic [fba_pkg::NUM_W-1:0]   num;

    assign prod = {g_ph_reg, {fba_pkg::SPLIT_W{1'b0}}} + fba_pkg::PROD_W'(g_pl_reg);
    assign num  = {prod, 2'b00};

    always_comb
    begin
        h_next      = '0;
        h_next.d2   = g_d2_reg;
        h_next.rem  = fba_pkg::D2_W'(num[fba_pkg::NUM_W-1:fba_pkg::X_W]);
        h_next.low  = num[fba_pkg::X_W-1:0];
        h_next.side = g_side_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            h_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            h_valid_reg <= g_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            h_reg <= h_next;
        end
    end

    // ------------------------------------------------------------------
    // Error: 34 divide stages then 17 root stages
    // ------------------------------------------------------------------
    logic           xr_valid;
    fba_pkg::sqrt_t xr;

    fba_xroot u_xroot (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .src_valid (h_valid_reg),
        .src       (h_reg),
        .dst_valid (xr_valid),
        .dst       (xr)
    );

    // ------------------------------------------------------------------
    // Result assembly; zero denominator overrides the datapath
    // ------------------------------------------------------------------
    fba_pkg::result_t fin;

    always_comb
    begin
        fin.asymmetry        = xr.side.zero ? '0 : xr.side.asym;
        fin.asym_error       = xr.side.zero ? fba_pkg::ERR_ONE : fba_pkg::ERR_W'(xr.root);
        fin.bin_time         = xr.side.btime;
        fin.zero_denominator = xr.side.zero;
        fin.saturated        = !xr.side.zero && xr.side.sat;
    end

    // ------------------------------------------------------------------
    // Output register plus skid register
    // ------------------------------------------------------------------
    fba_pkg::result_t out_reg;
    fba_pkg::result_t skid_reg;
    logic             push;
    logic             pop;

    assign push = adv && xr_valid;
    assign pop  = out_valid_reg && result_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            priority if (pop)
            begin
                if (skid_valid_reg)
                begin
                    skid_valid_reg <= 1'b0;
                end
                else
                begin
                    out_valid_reg <= push;
                end
            end
            else if (!out_valid_reg)
            begin
                out_valid_reg <= push;
            end
            else if (push)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                // full and not popped: hold
                skid_valid_reg <= skid_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        priority if (pop && skid_valid_reg)
        begin
            out_reg <= skid_reg;
        end
        else if (push && (pop || !out_valid_reg))
        begin
            out_reg <= fin;
        end
        else
        begin
            out_reg <= out_reg;
        end
        if (push && out_valid_reg && !pop)
        begin
            skid_reg <= fin;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register occupied while output register empty");

    a_sat_is_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.saturated |->
            result.asymmetry == fba_pkg::ASYM_MAX && !result.zero_denominator)
        else $error("saturated beat without clamped asymmetry");

    a_zero_den_values: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.zero_denominator |->
            result.asymmetry == '0 && result.asym_error == fba_pkg::ERR_ONE)
        else $error("zero denominator beat carries wrong values");

    a_err_bound: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.zero_denominator |-> result.asym_error < fba_pkg::ERR_BOUND)
        else $error("error estimate above its analytic bound");

endmodule

`default_nettype wire

// ===== design/fba_qdiv.sv =====
// fba_qdiv: pipelined restoring divider, one quotient bit per stage, giving
// |N|*2^15 / D with remainder. Depends on fba_pkg.
`default_nettype none

module fba_qdiv (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           en,
    input  wire logic           src_valid,
    input  wire fba_pkg::qdiv_t src,
    output logic                dst_valid,
    output fba_pkg::qdiv_t      dst
);

    localparam int STEPS = fba_pkg::QUO_W;

    logic           vld_reg [STEPS];
    fba_pkg::qdiv_t stg_reg [STEPS];

    for (genvar k = 0; k < STEPS; k++) begin : g_step
        fba_pkg::qdiv_t              prev;
        fba_pkg::qdiv_t              stage_next;
        logic                        prev_vld;
        logic [fba_pkg::DEN_W:0]     trial;
        logic [fba_pkg::DEN_W:0]     diff;
        logic                        ge;

        if (k == 0) begin : g_first
            assign prev     = src;
            assign prev_vld = src_valid;
        end else begin : g_rest
            assign prev     = stg_reg[k-1];
            assign prev_vld = vld_reg[k-1];
        end

        always_comb
        begin
            trial = {prev.rem, prev.nbit};
            diff  = trial - {1'b0, prev.den};
            ge    = trial >= {1'b0, prev.den};
            stage_next      = prev;
            stage_next.rem  = ge ? diff[fba_pkg::DEN_W-1:0] : trial[fba_pkg::DEN_W-1:0];
            stage_next.nbit = 1'b0;
            stage_next.quo  = {prev.quo[fba_pkg::QUO_W-2:0], ge};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[k] <= prev_vld;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                stg_reg[k] <= stage_next;
            end
        end
    end

    assign dst_valid = vld_reg[STEPS-1];
    assign dst       = stg_reg[STEPS-1];

endmodule

`default_nettype wire

// ===== design/fba_xroot.sv =====
// fba_xroot: pipelined long division Q1*Q2*4 / D^2 followed by a pipelined
// digit-by-digit integer square root. Depends on fba_pkg.
`default_nettype none

module fba_xroot (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           en,
    input  wire logic           src_valid,
    input  wire fba_pkg::xdiv_t src,
    output logic                dst_valid,
    output fba_pkg::sqrt_t      dst
);

    localparam int DSTEPS = fba_pkg::X_W;
    localparam int RSTEPS = fba_pkg::ROOT_W;

    logic           dv_reg [DSTEPS];
    fba_pkg::xdiv_t dd_reg [DSTEPS];
    logic           rv_reg [RSTEPS];
    fba_pkg::sqrt_t rd_reg [RSTEPS];

    // quotient bits, most significant first
    for (genvar k = 0; k < DSTEPS; k++) begin : g_div
        fba_pkg::xdiv_t          prev;
        fba_pkg::xdiv_t          stage_next;
        logic                    prev_vld;
        logic [fba_pkg::D2_W:0]  trial;
        logic [fba_pkg::D2_W:0]  diff;
        logic                    ge;

        if (k == 0) begin : g_first
            assign prev     = src;
            assign prev_vld = src_valid;
        end else begin : g_rest
            assign prev     = dd_reg[k-1];
            assign prev_vld = dv_reg[k-1];
        end

        always_comb
        begin
            trial = {prev.rem, prev.low[fba_pkg::X_W-1]};
            diff  = trial - {1'b0, prev.d2};
            ge    = trial >= {1'b0, prev.d2};
            stage_next     = prev;
            stage_next.rem = ge ? diff[fba_pkg::D2_W-1:0] : trial[fba_pkg::D2_W-1:0];
            stage_next.low = {prev.low[fba_pkg::X_W-2:0], 1'b0};
            stage_next.quo = {prev.quo[fba_pkg::X_W-2:0], ge};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                dv_reg[k] <= prev_vld;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dd_reg[k] <= stage_next;
            end
        end
    end

    // one root bit per stage, two radicand bits consumed per stage
    for (genvar j = 0; j < RSTEPS; j++) begin : g_root
        fba_pkg::sqrt_t                  prev;
        fba_pkg::sqrt_t                  stage_next;
        logic                            prev_vld;
        logic [fba_pkg::SQ_REM_W+1:0]    trial;
        logic [fba_pkg::SQ_REM_W+1:0]    test;
        logic [fba_pkg::SQ_REM_W+1:0]    diff;
        logic                            ge;

        if (j == 0) begin : g_first
            always_comb
            begin
                prev      = '0;
                prev.x    = dd_reg[DSTEPS-1].quo;
                prev.side = dd_reg[DSTEPS-1].side;
            end
            assign prev_vld = dv_reg[DSTEPS-1];
        end else begin : g_rest
            assign prev     = rd_reg[j-1];
            assign prev_vld = rv_reg[j-1];
        end

        always_comb
        begin
            trial = {prev.rem, prev.x[fba_pkg::X_W-1 -: 2]};
            test  = {2'b00, prev.root[fba_pkg::ROOT_W-2:0], 2'b01};
            diff  = trial - test;
            ge    = trial >= test;
            stage_next      = prev;
            stage_next.rem  = ge ? diff[fba_pkg::SQ_REM_W-1:0] : trial[fba_pkg::SQ_REM_W-1:0];
            stage_next.root = {prev.root[fba_pkg::ROOT_W-2:0], ge};
            stage_next.x    = {prev.x[fba_pkg::X_W-3:0], 2'b00};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                rv_reg[j] <= 1'b0;
            end
            else if (en)
            begin
                rv_reg[j] <= prev_vld;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rd_reg[j] <= stage_next;
            end
        end
    end

    assign dst_valid = rv_reg[RSTEPS-1];
    assign dst       = rd_reg[RSTEPS-1];

endmodule

`default_nettype wire
